[hdl/gfrw_pkg.sv]
// Shared types and constants for the geofence return-waypoint unit.
`timescale 1ns / 1ps
package gfrw_pkg;

    localparam int CFG_ADDR_W = 3;

    localparam logic [CFG_ADDR_W-1:0] CFG_SHAPE_KIND  = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_CENTER_X    = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_CENTER_Y    = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_RADIUS      = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_RECT_WIDTH  = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] CFG_RECT_HEIGHT = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] CFG_BACKTRACK   = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] CFG_ENABLED     = 3'd7;

    localparam logic [1:0] SHAPE_NONE   = 2'd0;
    localparam logic [1:0] SHAPE_CIRCLE = 2'd1;
    localparam logic [1:0] SHAPE_RECT   = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PREP,
        ST_SQX,
        ST_SQY,
        ST_SQR,
        ST_DECIDE,
        ST_ROOT,
        ST_MULX,
        ST_MULY,
        ST_DIVI,
        ST_DIV,
        ST_FIN
    } gfrw_state_t;

    typedef struct packed {
        logic load;
        logic prep;
        logic sq_x;
        logic sq_y;
        logic sq_r;
        logic decide;
        logic root_step;
        logic mul_x;
        logic mul_y;
        logic div_init;
        logic div_step;
        logic finish;
    } gfrw_cmd_t;

    typedef struct packed {
        logic go_root;
        logic out_free;
    } gfrw_sts_t;

endpackage

[hdl/geofence_return_waypoint_unit.sv]
// Top level of the geofence return-waypoint unit.
`timescale 1ns / 1ps
// Takes one position sample per s_ transfer, tests it strictly against the
// configured circle or rectangle and returns one result per sample on m_.
// An outside sample yields the work flag and a waypoint moved the configured
// backtrack step toward the centre (rounded to nearest, saturated); interrupt
// marks only the first outside sample after an inside one. An outside sample
// on the centre gives at_center and the waypoint equals the position. Timing:
// one sample at a time. An outside sample also runs the restoring square root
// (one root bit per cycle, 26 bits at the default width) and then the two
// restoring dividers running side by side (one quotient bit per cycle,
// COORD_BITS bits). A single multiplier is shared for the squares and the
// scaling products. The result sits in an output register, so the next sample
// is accepted while the previous result waits for m_tready. Configuration
// writes via cfg_we/cfg_addr/cfg_data are registered and must only happen
// while no sample is in flight.
module geofence_return_waypoint_unit
    import gfrw_pkg::*;
#(
    parameter int COORD_BITS    = 24,
    parameter int FRACTION_BITS = 8
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // loc_x, loc_y (low to high), zero padded to bytes
    input  logic [((2*COORD_BITS+7)/8)*8-1:0] s_tdata,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // waypoint_x, waypoint_y (low to high), zero padded to bytes
    output logic [((2*COORD_BITS+7)/8)*8-1:0] m_tdata,
    // interrupt, work flag, at_center (low to high)
    output logic [2:0]                  m_tuser,
    input  logic                        cfg_we,
    input  logic [CFG_ADDR_W-1:0]       cfg_addr,
    input  logic [COORD_BITS-1:0]       cfg_data
);

    localparam int BUS_W = ((2*COORD_BITS+7)/8)*8;

    gfrw_cmd_t cmd;
    gfrw_sts_t sts;
    logic      irq, work, atc;
    logic signed [COORD_BITS-1:0] wx, wy;

    gfrw_ctrl #(
        .COORD_BITS (COORD_BITS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    gfrw_dp #(
        .COORD_BITS    (COORD_BITS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_addr   (cfg_addr),
        .cfg_data   (cfg_data),
        .loc_x      (s_tdata[COORD_BITS-1:0]),
        .loc_y      (s_tdata[2*COORD_BITS-1:COORD_BITS]),
        .cmd        (cmd),
        .sts        (sts),
        .out_ready  (m_tready),
        .out_valid  (m_tvalid),
        .interrupt  (irq),
        .work_flag  (work),
        .at_center  (atc),
        .waypoint_x (wx),
        .waypoint_y (wy)
    );

    assign m_tdata = BUS_W'({wy, wx});
    assign m_tuser = {atc, work, irq};

endmodule

[hdl/gfrw_ctrl.sv]
// Sequencing state machine for the geofence return-waypoint unit.
`timescale 1ns / 1ps
module gfrw_ctrl
    import gfrw_pkg::*;
#(
    parameter int COORD_BITS = 24
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  gfrw_sts_t sts,
    output gfrw_cmd_t cmd
);

    localparam int AW   = COORD_BITS + 1;
    localparam int SW   = (AW > 31) ? 31 : AW;
    localparam int RTW  = SW + 1;
    localparam int QW   = COORD_BITS;
    localparam int MAXN = (RTW > QW) ? RTW : QW;
    localparam int CNTW = $clog2(MAXN);

    gfrw_state_t state_reg, state_next;
    logic [CNTW-1:0] cnt_reg, cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_IDLE:   if (in_valid) state_next = ST_PREP;
            ST_PREP:   state_next = ST_SQX;
            ST_SQX:    state_next = ST_SQY;
            ST_SQY:    state_next = ST_SQR;
            ST_SQR:    state_next = ST_DECIDE;
            ST_DECIDE:
            begin
                cnt_next   = '0;
                state_next = sts.go_root ? ST_ROOT : ST_FIN;
            end
            ST_ROOT:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNTW'(RTW - 1))
                    state_next = ST_MULX;
            end
            ST_MULX:   state_next = ST_MULY;
            ST_MULY:   state_next = ST_DIVI;
            ST_DIVI:
            begin
                cnt_next   = '0;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNTW'(QW - 1))
                    state_next = ST_FIN;
            end
            ST_FIN:    if (sts.out_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_PREP:   cmd.prep      = 1'b1;
            ST_SQX:    cmd.sq_x      = 1'b1;
            ST_SQY:    cmd.sq_y      = 1'b1;
            ST_SQR:    cmd.sq_r      = 1'b1;
            ST_DECIDE: cmd.decide    = 1'b1;
            ST_ROOT:   cmd.root_step = 1'b1;
            ST_MULX:   cmd.mul_x     = 1'b1;
            ST_MULY:   cmd.mul_y     = 1'b1;
            ST_DIVI:   cmd.div_init  = 1'b1;
            ST_DIV:    cmd.div_step  = 1'b1;
            ST_FIN:    cmd.finish    = sts.out_free;
            default:   cmd = '0;
        endcase
    end

endmodule

[hdl/gfrw_dp.sv]
// Datapath: config registers, shared multiplier, square root, dividers, output register.
`timescale 1ns / 1ps
module gfrw_dp
    import gfrw_pkg::*;
#(
    parameter int COORD_BITS    = 24,
    parameter int FRACTION_BITS = 8
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [CFG_ADDR_W-1:0]        cfg_addr,
    input  logic [COORD_BITS-1:0]        cfg_data,
    input  logic signed [COORD_BITS-1:0] loc_x,
    input  logic signed [COORD_BITS-1:0] loc_y,
    input  gfrw_cmd_t                    cmd,
    output gfrw_sts_t                    sts,
    input  logic                         out_ready,
    output logic                         out_valid,
    output logic                         interrupt,
    output logic                         work_flag,
    output logic                         at_center,
    output logic signed [COORD_BITS-1:0] waypoint_x,
    output logic signed [COORD_BITS-1:0] waypoint_y
);

    localparam int CB   = COORD_BITS;
    localparam int DW   = COORD_BITS - 1;
    localparam int AW   = COORD_BITS + 1;
    localparam int SW   = (AW > 31) ? 31 : AW;
    localparam int SQW  = 2 * SW + 1;
    localparam int RTW  = SW + 1;
    localparam int REMW = RTW + 2;
    localparam int PW   = DW + SW;
    localparam int NUMW = DW + SW + 2;
    localparam int DENW = RTW + 1;
    localparam int QW   = COORD_BITS;

    // configuration
    logic [1:0]           shape_kind_reg;
    logic signed [CB-1:0] center_x_reg, center_y_reg;
    logic [DW-1:0]        radius_reg, rect_width_reg, rect_height_reg, backtrack_reg;
    logic                 enabled_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shape_kind_reg  <= SHAPE_NONE;
            center_x_reg    <= '0;
            center_y_reg    <= '0;
            radius_reg      <= '0;
            rect_width_reg  <= '0;
            rect_height_reg <= '0;
            backtrack_reg   <= DW'(1) << FRACTION_BITS;
            enabled_reg     <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                CFG_SHAPE_KIND:  shape_kind_reg  <= cfg_data[1:0];
                CFG_CENTER_X:    center_x_reg    <= cfg_data;
                CFG_CENTER_Y:    center_y_reg    <= cfg_data;
                CFG_RADIUS:      radius_reg      <= cfg_data[DW-1:0];
                CFG_RECT_WIDTH:  rect_width_reg  <= cfg_data[DW-1:0];
                CFG_RECT_HEIGHT: rect_height_reg <= cfg_data[DW-1:0];
                CFG_BACKTRACK:   backtrack_reg   <= cfg_data[DW-1:0];
                CFG_ENABLED:     enabled_reg     <= cfg_data[0];
                default:         enabled_reg     <= enabled_reg;
            endcase
        end
    end

    // working registers
    logic signed [CB-1:0] x_reg, y_reg;
    logic                 vxneg_reg, vyneg_reg, vzero_reg, rect_in_reg, circ_far_reg;
    logic [SW-1:0]        sx_reg, sy_reg;
    logic [2*SW-1:0]      prod_reg;
    logic [SQW-1:0]       sum_reg;
    logic [PW-1:0]        px_reg;
    logic                 outside_reg, irq_reg, rr_reg;
    logic [2*RTW-1:0]     rad_reg;
    logic [REMW-1:0]      rem_reg;
    logic [RTW-1:0]       root_reg;
    logic [DENW-1:0]      den_reg, remx_reg, remy_reg;
    logic [QW-1:0]        qx_reg, qy_reg;

    // offset vector, magnitudes, scaling
    logic signed [CB:0] vx, vy;
    logic [AW-1:0]      ax, ay, shx, shy;
    always_comb
    begin
        vx  = {center_x_reg[CB-1], center_x_reg} - {x_reg[CB-1], x_reg};
        vy  = {center_y_reg[CB-1], center_y_reg} - {y_reg[CB-1], y_reg};
        ax  = vx[CB] ? AW'(~vx + 1'b1) : AW'(vx);
        ay  = vy[CB] ? AW'(~vy + 1'b1) : AW'(vy);
        shx = ax;
        shy = ay;
        for (int k = 0; k < AW - SW; k++)
        begin
            if ((shx | shy) >= (AW'(1) << SW))
            begin
                shx = shx >> 1;
                shy = shy >> 1;
            end
        end
    end

    // rectangle test, doubled coordinates
    logic signed [CB+2:0] x2, y2, cx2, cy2, w3, h3;
    logic                 rect_in;
    always_comb
    begin
        x2  = {{2{x_reg[CB-1]}}, x_reg, 1'b0};
        y2  = {{2{y_reg[CB-1]}}, y_reg, 1'b0};
        cx2 = {{2{center_x_reg[CB-1]}}, center_x_reg, 1'b0};
        cy2 = {{2{center_y_reg[CB-1]}}, center_y_reg, 1'b0};
        w3  = {4'b0000, rect_width_reg};
        h3  = {4'b0000, rect_height_reg};
        rect_in = (x2 < cx2 + w3) && (x2 > cx2 - w3) &&
                  (y2 < cy2 + h3) && (y2 > cy2 - h3);
    end

    // shared multiplier
    logic [SW-1:0]   mul_a, mul_b;
    logic [2*SW-1:0] mul_p;
    always_comb
    begin
        mul_a = sx_reg;
        mul_b = sx_reg;
        if (cmd.sq_y)
        begin
            mul_a = sy_reg;
            mul_b = sy_reg;
        end
        else if (cmd.sq_r)
        begin
            mul_a = SW'(radius_reg);
            mul_b = SW'(radius_reg);
        end
        else if (cmd.mul_x)
        begin
            mul_a = SW'(backtrack_reg);
            mul_b = sx_reg;
        end
        else if (cmd.mul_y)
        begin
            mul_a = SW'(backtrack_reg);
            mul_b = sy_reg;
        end
        mul_p = mul_a * mul_b;
    end

    // outside decision, sum_reg holds the squared norm, prod_reg the squared radius
    logic shape_ok, inside_now, outside_now;
    always_comb
    begin
        shape_ok = shape_kind_reg inside {SHAPE_CIRCLE, SHAPE_RECT};
        if (shape_kind_reg == SHAPE_CIRCLE)
            inside_now = !circ_far_reg && (sum_reg < SQW'(prod_reg));
        else
            inside_now = rect_in_reg;
        outside_now = enabled_reg && shape_ok && !inside_now;
    end

    assign sts.go_root  = outside_now && !vzero_reg;
    assign sts.out_free = !out_valid || out_ready;

    // one root digit per cycle
    logic [REMW+1:0] rem2, trial;
    logic            root_ge;
    always_comb
    begin
        rem2    = {rem_reg, rad_reg[2*RTW-1 -: 2]};
        trial   = (REMW+2)'({root_reg, 2'b01});
        root_ge = rem2 >= trial;
    end

    // divider setup and one quotient bit per cycle
    logic [NUMW-1:0] numx, numy;
    logic [DENW:0]   tx, ty;
    logic            gex, gey;
    always_comb
    begin
        numx = NUMW'({px_reg, 1'b0}) + NUMW'(root_reg);
        numy = NUMW'({prod_reg[PW-1:0], 1'b0}) + NUMW'(root_reg);
        tx   = {remx_reg, qx_reg[QW-1]};
        ty   = {remy_reg, qy_reg[QW-1]};
        gex  = tx >= {1'b0, den_reg};
        gey  = ty >= {1'b0, den_reg};
    end

    // final waypoint with saturation
    localparam logic signed [CB+1:0] SAT_HI = (CB+2)'((64'd1 << (CB - 1)) - 64'd1);
    localparam logic signed [CB+1:0] SAT_LO = -SAT_HI - 1;
    logic signed [CB+1:0] offx, offy, sumx, sumy;
    logic signed [CB-1:0] satx, saty;
    always_comb
    begin
        offx = signed'({2'b00, qx_reg});
        offy = signed'({2'b00, qy_reg});
        sumx = {{2{x_reg[CB-1]}}, x_reg} + (vxneg_reg ? -offx : offx);
        sumy = {{2{y_reg[CB-1]}}, y_reg} + (vyneg_reg ? -offy : offy);
        if (sumx > SAT_HI)
            satx = SAT_HI[CB-1:0];
        else if (sumx < SAT_LO)
            satx = SAT_LO[CB-1:0];
        else
            satx = sumx[CB-1:0];
        if (sumy > SAT_HI)
            saty = SAT_HI[CB-1:0];
        else if (sumy < SAT_LO)
            saty = SAT_LO[CB-1:0];
        else
            saty = sumy[CB-1:0];
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            x_reg <= loc_x;
            y_reg <= loc_y;
        end
        if (cmd.prep)
        begin
            vxneg_reg    <= vx[CB];
            vyneg_reg    <= vy[CB];
            vzero_reg    <= (vx == '0) && (vy == '0);
            rect_in_reg  <= rect_in;
            circ_far_reg <= (ax >= AW'(radius_reg)) || (ay >= AW'(radius_reg));
            sx_reg       <= shx[SW-1:0];
            sy_reg       <= shy[SW-1:0];
        end
        if (cmd.sq_x || cmd.sq_y || cmd.sq_r || cmd.mul_x || cmd.mul_y)
            prod_reg <= mul_p;
        if (cmd.sq_y)
            sum_reg <= SQW'(prod_reg);
        if (cmd.sq_r)
            sum_reg <= sum_reg + SQW'(prod_reg);
        if (cmd.decide)
        begin
            rad_reg  <= (2*RTW)'(sum_reg);
            rem_reg  <= '0;
            root_reg <= '0;
        end
        if (cmd.root_step)
        begin
            rad_reg  <= rad_reg << 2;
            rem_reg  <= root_ge ? REMW'(rem2 - trial) : REMW'(rem2);
            root_reg <= {root_reg[RTW-2:0], root_ge};
        end
        if (cmd.mul_y)
            px_reg <= prod_reg[PW-1:0];
        if (cmd.div_init)
        begin
            den_reg  <= {root_reg, 1'b0};
            remx_reg <= DENW'(numx >> QW);
            remy_reg <= DENW'(numy >> QW);
            qx_reg   <= numx[QW-1:0];
            qy_reg   <= numy[QW-1:0];
        end
        if (cmd.div_step)
        begin
            remx_reg <= gex ? DENW'(tx - {1'b0, den_reg}) : DENW'(tx);
            remy_reg <= gey ? DENW'(ty - {1'b0, den_reg}) : DENW'(ty);
            qx_reg   <= {qx_reg[QW-2:0], gex};
            qy_reg   <= {qy_reg[QW-2:0], gey};
        end
        if (cmd.finish)
        begin
            interrupt <= irq_reg;
            work_flag <= outside_reg;
            at_center <= outside_reg && vzero_reg;
            if (!outside_reg)
            begin
                waypoint_x <= '0;
                waypoint_y <= '0;
            end
            else if (vzero_reg)
            begin
                waypoint_x <= x_reg;
                waypoint_y <= y_reg;
            end
            else
            begin
                waypoint_x <= satx;
                waypoint_y <= saty;
            end
        end
    end

    // latch and control flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rr_reg      <= 1'b0;
            irq_reg     <= 1'b0;
            outside_reg <= 1'b0;
            out_valid   <= 1'b0;
        end
        else
        begin
            if (cmd.decide)
            begin
                outside_reg <= outside_now;
                irq_reg     <= outside_now && !rr_reg;
                rr_reg      <= outside_now;
            end
            if (cmd.finish)
                out_valid <= 1'b1;
            else if (out_ready)
                out_valid <= 1'b0;
        end
    end

endmodule

[hdl/gfrw_checker.sv]
// Port-level checks for the geofence return-waypoint unit, bound to the top level.
`timescale 1ns / 1ps
module gfrw_checker
#(
    parameter int COORD_BITS = 24
)
(
    input logic                                  clk,
    input logic                                  rst_n,
    input logic                                  m_tvalid,
    input logic                                  m_tready,
    input logic [((2*COORD_BITS+7)/8)*8-1:0]     m_tdata,
    input logic [2:0]                            m_tuser
);

    // a stalled result stays offered
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // interrupt only on an outside sample
    a_irq_work: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tuser[1])
        else $error("interrupt without work flag");

    // at_center only on an outside sample
    a_atc_work: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[2] |-> m_tuser[1])
        else $error("at_center without work flag");

    // inside results carry a zero waypoint
    a_inside_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[1] |-> m_tdata == '0)
        else $error("nonzero waypoint on inside sample");

endmodule

bind geofence_return_waypoint_unit gfrw_checker #(
    .COORD_BITS (COORD_BITS)
) u_gfrw_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
